FILE: rtl/core/sfd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sfd_pkg
// Shared types and constants for the status frame deframer.
// ============================================================================
package sfd_pkg;

    // Parser state: one state per field of the frame.
    typedef enum logic [2:0] {
        S_HUNT,
        S_LEN_HI,
        S_LEN_LO,
        S_PAYLOAD,
        S_CRC_HI,
        S_CRC_LO,
        S_END
    } t_state;

    typedef logic [1:0] t_frame_status;

    localparam t_frame_status FS_NONE    = 2'd0;
    localparam t_frame_status FS_GOOD    = 2'd1;
    localparam t_frame_status FS_CRC_ERR = 2'd2;
    localparam t_frame_status FS_END_ERR = 2'd3;

    localparam logic [7:0]  START_SHORT   = 8'h02;
    localparam logic [7:0]  START_LONG    = 8'h03;
    localparam logic [7:0]  END_BYTE      = 8'h03;
    localparam logic [7:0]  OPCODE_RESET  = 8'd50;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] FIELD_FIRST   = 16'd5;
    localparam logic [15:0] FIELD_LAST    = 16'd18;
    localparam logic [15:0] MIN_STAT_LEN  = 16'd19;

endpackage

FILE: rtl/core/sfd_crc16_byte.sv
`timescale 1ns / 1ps
// ============================================================================
// sfd_crc16_byte
// One-byte update of CRC-16 (polynomial 0x1021, MSB first), combinational.
// ============================================================================
module sfd_crc16_byte
    import sfd_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] v_r;
        v_r = i_crc ^ {i_data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (v_r[15]) begin
                v_r = {v_r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v_r = {v_r[14:0], 1'b0};
            end
        end
        o_crc = v_r;
    end

endmodule

FILE: rtl/core/status_frame_deframer_crc16.sv
`timescale 1ns / 1ps
// The result of an accepted word is registered at the clock edge that accepts it.
// One word per cycle while o_ready is high; next-state and CRC logic are combinational.
// A stalled result output holds the input off only while the result register is full.
// Reset (i_rst_n low, synchronous) returns the parser to hunting, clears all values,
// empties the result register and loads the status opcode register with 50.
// ============================================================================
// status_frame_deframer_crc16
// Deframes motor-controller status packets from a received byte stream, checks
// the CRC-16 over the payload and commits the signed status fields of good frames.
// ============================================================================
module status_frame_deframer_crc16
    import sfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration: status opcode register.
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    // Input channel.
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_resync,
    // Result channel.
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_frame_status,
    output logic               o_values_updated,
    output logic signed [31:0] o_current_x100,
    output logic signed [31:0] o_rpm_x100,
    output logic signed [15:0] o_voltage_x10,
    output logic signed [31:0] o_distance_count
);

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    t_state                r_state,   n_state;
    logic                  r_long,    n_long;
    logic [15:0]           r_len,     n_len;
    logic [15:0]           r_idx,     n_idx;
    logic [15:0]           r_crc,     n_crc;
    logic [15:0]           r_rx_crc,  n_rx_crc;
    logic [7:0]            r_first,   n_first;
    logic [111:0]          r_pend,    n_pend;
    logic signed [31:0]    r_cur,     n_cur;
    logic signed [31:0]    r_rpm,     n_rpm;
    logic signed [15:0]    r_volt,    n_volt;
    logic signed [31:0]    r_dist,    n_dist;
    t_frame_status         r_status,  n_status;
    logic                  r_upd,     n_upd;
    logic                  r_out_valid;
    logic [7:0]            r_opcode;

    logic                  w_accept;
    t_state                w_cur;
    logic [15:0]           w_crc_next;
    logic [15:0]           w_len_long;
    logic                  w_commit;

    // The input is taken whenever the result register is empty or is being
    // emptied in this same cycle, so the result of every accepted word has a
    // place to go at the same clock edge.
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // A resync word drops any partial frame and is parsed as if hunting.
    assign w_cur = i_resync ? S_HUNT : r_state;

    // Full 16-bit length once the second length byte arrives.
    assign w_len_long = {r_len[7:0], i_data_byte};

    sfd_crc16_byte u_crc (
        .i_crc  (r_crc),
        .i_data (i_data_byte),
        .o_crc  (w_crc_next)
    );

    // A frame commits its fields only if the end byte is right, the CRC
    // matches, the opcode is the status opcode and all fields were received.
    assign w_commit = (i_data_byte == END_BYTE) && (r_crc == r_rx_crc)
                   && (r_first == r_opcode) && (r_len >= MIN_STAT_LEN);

    // ------------------------------------------------------------------------
    // Next-state logic of the parser.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        if (w_accept) begin
            unique case (w_cur)
                S_HUNT: begin
                    if (i_data_byte == START_SHORT || i_data_byte == START_LONG) begin
                        n_state = S_LEN_HI;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
                S_LEN_HI: begin
                    if (r_long) begin
                        n_state = S_LEN_LO;
                    end else if (i_data_byte == 8'h00) begin
                        n_state = S_CRC_HI;
                    end else begin
                        n_state = S_PAYLOAD;
                    end
                end
                S_LEN_LO: begin
                    n_state = (w_len_long == 16'h0000) ? S_CRC_HI : S_PAYLOAD;
                end
                S_PAYLOAD: begin
                    n_state = (r_idx + 16'd1 == r_len) ? S_CRC_HI : S_PAYLOAD;
                end
                S_CRC_HI: n_state = S_CRC_LO;
                S_CRC_LO: n_state = S_END;
                S_END:    n_state = S_HUNT;
                default:  n_state = S_HUNT;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Datapath and result logic of the parser.
    // ------------------------------------------------------------------------
    always_comb begin
        n_long   = r_long;
        n_len    = r_len;
        n_idx    = r_idx;
        n_crc    = r_crc;
        n_rx_crc = r_rx_crc;
        n_first  = r_first;
        n_pend   = r_pend;
        n_cur    = r_cur;
        n_rpm    = r_rpm;
        n_volt   = r_volt;
        n_dist   = r_dist;
        n_status = FS_NONE;
        n_upd    = 1'b0;
        unique case (w_cur)
            S_HUNT: begin
                if (i_data_byte == START_SHORT || i_data_byte == START_LONG) begin
                    n_long   = (i_data_byte == START_LONG);
                    n_len    = 16'h0000;
                    n_crc    = 16'h0000;
                    n_rx_crc = 16'h0000;
                    n_first  = 8'h00;
                end
            end
            S_LEN_HI: begin
                n_len = {8'h00, i_data_byte};
                n_idx = 16'h0000;
            end
            S_LEN_LO: begin
                n_len = w_len_long;
                n_idx = 16'h0000;
            end
            S_PAYLOAD: begin
                n_crc = w_crc_next;
                n_idx = r_idx + 16'd1;
                if (r_idx == 16'h0000) begin
                    n_first = i_data_byte;
                end
                // Payload bytes 5 through 18 shift in, first byte ending on top.
                if (r_idx >= FIELD_FIRST && r_idx <= FIELD_LAST) begin
                    n_pend = {r_pend[103:0], i_data_byte};
                end
            end
            S_CRC_HI: n_rx_crc = {i_data_byte, 8'h00};
            S_CRC_LO: n_rx_crc = {r_rx_crc[15:8], i_data_byte};
            S_END: begin
                if (i_data_byte != END_BYTE) begin
                    n_status = FS_END_ERR;
                end else if (r_crc != r_rx_crc) begin
                    n_status = FS_CRC_ERR;
                end else begin
                    n_status = FS_GOOD;
                end
                if (w_commit) begin
                    n_cur  = r_pend[111:80];
                    n_rpm  = r_pend[79:48];
                    n_volt = r_pend[47:32];
                    n_dist = r_pend[31:0];
                    n_upd  = 1'b1;
                end
            end
            default: begin
                n_status = FS_NONE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // State, configuration and result registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HUNT;
            r_long      <= 1'b0;
            r_len       <= 16'h0000;
            r_idx       <= 16'h0000;
            r_crc       <= 16'h0000;
            r_rx_crc    <= 16'h0000;
            r_first     <= 8'h00;
            r_pend      <= '0;
            r_cur       <= '0;
            r_rpm       <= '0;
            r_volt      <= '0;
            r_dist      <= '0;
            r_status    <= FS_NONE;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
            r_opcode    <= OPCODE_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_opcode <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_long   <= n_long;
                r_len    <= n_len;
                r_idx    <= n_idx;
                r_crc    <= n_crc;
                r_rx_crc <= n_rx_crc;
                r_first  <= n_first;
                r_pend   <= n_pend;
                r_cur    <= n_cur;
                r_rpm    <= n_rpm;
                r_volt   <= n_volt;
                r_dist   <= n_dist;
                r_status <= n_status;
                r_upd    <= n_upd;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The committed values change only when a word is accepted, which is also
    // the only time the result register loads, so they drive the ports directly.
    assign o_valid          = r_out_valid;
    assign o_frame_status   = r_status;
    assign o_values_updated = r_upd;
    assign o_current_x100   = r_cur;
    assign o_rpm_x100       = r_rpm;
    assign o_voltage_x10    = r_volt;
    assign o_distance_count = r_dist;

`ifndef SYNTHESIS
    a_upd_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_values_updated) |-> (o_frame_status == FS_GOOD))
        else $error("values committed on a frame that was not good");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_resync || r_state != S_END)) |=> (o_frame_status == FS_NONE))
        else $error("frame status reported outside the end byte");

    a_values_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !o_values_updated) |->
            ($stable(o_current_x100) && $stable(o_rpm_x100)
             && $stable(o_voltage_x10) && $stable(o_distance_count)))
        else $error("status values changed without a commit");
`endif

endmodule
